>>> rtl/pirt_pkg.sv
`default_nettype none

package pirt_pkg;

  // Port widths fixed by the item format
  localparam int unsigned PORT_OFS_W = 32;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CODE_W     = 2;

  // Input item modes
  localparam logic [MODE_W-1:0] MODE_SEED   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IF     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ELIF   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ELSE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ENDIF  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FINISH = 3'd5;

  // Result item kinds
  localparam logic [KIND_W-1:0] KIND_REGION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEVEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  // Stack operations handed from the front end to the stack engine
  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_ELIF   = 3'd1,
    OP_ELSE   = 3'd2,
    OP_ENDIF  = 3'd3,
    OP_FINISH = 3'd4
  } op_t;

  // Control part of one queued command
  //   flag:  pending for a push, condition inactive for a directive
  //   taken: taken bit for a push
  typedef struct packed {
    op_t  op;
    logic flag;
    logic taken;
  } cmd_ctl_t;

endpackage

`default_nettype wire

>>> rtl/pirt_front.sv
`default_nettype none

module pirt_front #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [pirt_pkg::MODE_W-1:0]        mode,
  input  wire logic                               condition_inactive,
  input  wire logic [pirt_pkg::PORT_OFS_W-1:0]    line_start,
  input  wire logic [pirt_pkg::PORT_OFS_W-1:0]    after_line,
  input  wire logic [pirt_pkg::CODE_W-1:0]        seed_code,
  input  wire logic [pirt_pkg::PORT_OFS_W-1:0]    bound_offset,
  input  wire logic                               cmd_full,
  output logic                                    cmd_push,
  output pirt_pkg::cmd_ctl_t                      cmd_ctl,
  output logic [OFFSET_BITS-1:0]                  cmd_a,
  output logic [OFFSET_BITS-1:0]                  cmd_b
);

  logic                   known;
  logic [OFFSET_BITS-1:0] ls;
  logic [OFFSET_BITS-1:0] al;
  logic [OFFSET_BITS-1:0] bo;

  assign ls = line_start[OFFSET_BITS-1:0];
  assign al = after_line[OFFSET_BITS-1:0];
  assign bo = bound_offset[OFFSET_BITS-1:0];

  // Hold the sender while the queue is full; unused modes are taken and dropped
  assign in_stall = cmd_full;
  assign cmd_push = in_valid && !cmd_full && known;

  // Classify the item and build the stack command
  always_comb begin
    known         = 1'b1;
    cmd_ctl.op    = pirt_pkg::OP_PUSH;
    cmd_ctl.flag  = condition_inactive;
    cmd_ctl.taken = 1'b0;
    cmd_a         = al;
    cmd_b         = ls;
    unique case (mode)
      pirt_pkg::MODE_SEED: begin
        cmd_ctl.flag  = seed_code[0];
        cmd_ctl.taken = seed_code[1];
        cmd_a         = bo;
      end
      pirt_pkg::MODE_IF: begin
        cmd_ctl.taken = !condition_inactive;
        cmd_a         = condition_inactive ? al : '0;
      end
      pirt_pkg::MODE_ELIF:  cmd_ctl.op = pirt_pkg::OP_ELIF;
      pirt_pkg::MODE_ELSE:  cmd_ctl.op = pirt_pkg::OP_ELSE;
      pirt_pkg::MODE_ENDIF: cmd_ctl.op = pirt_pkg::OP_ENDIF;
      pirt_pkg::MODE_FINISH: begin
        cmd_ctl.op = pirt_pkg::OP_FINISH;
        cmd_b      = bo;
      end
      default: known = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/pirt_queue.sv
`default_nettype none

module pirt_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output logic [DATA_W-1:0]      head_data
);

  logic [DATA_W-1:0] slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_data  = slot[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pirt_back.sv
`default_nettype none

module pirt_back #(
  parameter int unsigned MAX_DEPTH   = 32,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  input  wire pirt_pkg::cmd_ctl_t               cmd_ctl,
  input  wire logic [OFFSET_BITS-1:0]           cmd_a,
  input  wire logic [OFFSET_BITS-1:0]           cmd_b,
  output logic                                  cmd_pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [pirt_pkg::KIND_W-1:0]           item_kind,
  output logic                                  region_valid,
  output logic [pirt_pkg::PORT_OFS_W-1:0]       region_begin,
  output logic [pirt_pkg::PORT_OFS_W-1:0]       region_end,
  output logic [pirt_pkg::CODE_W-1:0]           level_code,
  output logic                                  depth_overflow,
  output logic                                  last
);

  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned ENT_W = OFFSET_BITS + 2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_FIN   = 4'b0100,
    S_EMPTY = 4'b1000
  } state_t;

  state_t state, state_next;

  // Level stack: {pending, taken, begin}
  logic [ENT_W-1:0] level_mem [MAX_DEPTH];
  logic [ENT_W-1:0] rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] idx, idx_next;
  logic             ovf, ovf_next;

  // Latched command
  pirt_pkg::cmd_ctl_t     cur_ctl;
  logic [OFFSET_BITS-1:0] cur_a;
  logic [OFFSET_BITS-1:0] cur_b;

  logic                   e_pending;
  logic                   e_taken;
  logic [OFFSET_BITS-1:0] e_begin;
  logic                   e_hit;
  logic                   out_free;

  logic                        load;
  logic [pirt_pkg::KIND_W-1:0] kind_n;
  logic                        rv_n;
  logic [OFFSET_BITS-1:0]      rb_n;
  logic [OFFSET_BITS-1:0]      re_n;
  logic [pirt_pkg::CODE_W-1:0] code_n;
  logic                        last_n;

  assign count_m1  = count - CNT_W'(1);
  assign top_idx   = count_m1[IDX_W-1:0];
  assign e_pending = rdata[ENT_W-1];
  assign e_taken   = rdata[ENT_W-2];
  assign e_begin   = rdata[OFFSET_BITS-1:0];
  assign e_hit     = e_pending && (e_begin < cur_b);
  assign out_free  = !out_valid || !out_stall;
  assign cmd_pop   = (state == S_IDLE) && cmd_valid;

  // Sequence the stack operations
  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    ovf_next   = ovf;
    mem_we     = 1'b0;
    mem_waddr  = top_idx;
    mem_wdata  = rdata;
    mem_re     = 1'b0;
    mem_raddr  = top_idx;
    load       = 1'b0;
    kind_n     = pirt_pkg::KIND_REGION;
    rv_n       = 1'b0;
    rb_n       = '0;
    re_n       = '0;
    code_n     = '0;
    last_n     = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd_ctl.op)
            pirt_pkg::OP_PUSH: begin
              if (count == CNT_W'(MAX_DEPTH)) begin
                ovf_next = 1'b1;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = count[IDX_W-1:0];
                mem_wdata  = {cmd_ctl.flag, cmd_ctl.taken, cmd_a};
                count_next = count + CNT_W'(1);
              end
            end
            pirt_pkg::OP_FINISH: begin
              if (count == '0) begin
                state_next = S_EMPTY;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = S_FIN;
              end
            end
            default: begin
              // Directive on an empty stack is dropped
              if (count != '0) begin
                mem_re     = 1'b1;
                state_next = S_EXEC;
              end
            end
          endcase
        end
      end
      S_EXEC: begin
        if (!e_hit || out_free) begin
          state_next = S_IDLE;
          load       = e_hit;
          rv_n       = 1'b1;
          rb_n       = e_begin;
          re_n       = cur_b;
          unique case (cur_ctl.op)
            pirt_pkg::OP_ELIF: begin
              mem_we    = 1'b1;
              mem_wdata = {cur_ctl.flag, e_taken | !cur_ctl.flag,
                           cur_ctl.flag ? cur_a : e_begin};
            end
            pirt_pkg::OP_ELSE: begin
              mem_we    = 1'b1;
              mem_wdata = {e_taken, e_taken, e_taken ? cur_a : e_begin};
            end
            pirt_pkg::OP_ENDIF: count_next = count_m1;
            default: ;
          endcase
        end
      end
      S_FIN: begin
        if (out_free) begin
          load   = 1'b1;
          kind_n = pirt_pkg::KIND_LEVEL;
          rv_n   = e_hit;
          rb_n   = e_hit ? e_begin : '0;
          re_n   = e_hit ? cur_b : '0;
          code_n = {e_taken, e_pending};
          last_n = (idx == top_idx);
          if (idx == top_idx) begin
            count_next = '0;
            state_next = S_IDLE;
          end else begin
            idx_next  = idx + IDX_W'(1);
            mem_re    = 1'b1;
            mem_raddr = idx + IDX_W'(1);
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          load       = 1'b1;
          kind_n     = pirt_pkg::KIND_EMPTY;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the command and the walk index
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd_pop) begin
      cur_ctl <= cmd_ctl;
      cur_a   <= cmd_a;
      cur_b   <= cmd_b;
    end
  end

  // Level stack memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      level_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= level_mem[mem_raddr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      item_kind      <= kind_n;
      region_valid   <= rv_n;
      region_begin   <= pirt_pkg::PORT_OFS_W'(rb_n);
      region_end     <= pirt_pkg::PORT_OFS_W'(re_n);
      level_code     <= code_n;
      depth_overflow <= ovf;
      last           <= last_n;
    end
  end

endmodule

`default_nettype wire

>>> rtl/preprocessor_inactive_region_tracker.sv
`default_nettype none

// Tracks nested conditional-compilation directives and reports inactive
// source regions. Items are taken into a two-entry command queue, so the
// sender keeps moving while the stack engine works or the result side is
// stalled, until the queue fills. The level stack is a single memory with
// a registered read port, and that port sets the steps per item: a seed or
// if push is written at once, an elif, else or endif on a non-empty stack
// first reads the top level, then updates it and issues any closed region,
// and a finish reads the bottom level, then gives one report per cycle
// while the output is not stalled, bottom first, or the single empty-stack
// result. Unused modes and directives on an empty stack are taken and give
// nothing. Pushes beyond MAX_DEPTH are dropped and set a sticky overflow
// flag that rides on every result. The stack needs no clearing after
// reset; offsets are taken modulo 2^OFFSET_BITS.
module preprocessor_inactive_region_tracker #(
  parameter int unsigned MAX_DEPTH   = 32,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [pirt_pkg::MODE_W-1:0]      mode,
  input  wire logic                             condition_inactive,
  input  wire logic [pirt_pkg::PORT_OFS_W-1:0]  line_start,
  input  wire logic [pirt_pkg::PORT_OFS_W-1:0]  after_line,
  input  wire logic [pirt_pkg::CODE_W-1:0]      seed_code,
  input  wire logic [pirt_pkg::PORT_OFS_W-1:0]  bound_offset,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [pirt_pkg::KIND_W-1:0]           item_kind,
  output logic                                  region_valid,
  output logic [pirt_pkg::PORT_OFS_W-1:0]       region_begin,
  output logic [pirt_pkg::PORT_OFS_W-1:0]       region_end,
  output logic [pirt_pkg::CODE_W-1:0]           level_code,
  output logic                                  depth_overflow,
  output logic                                  last
);

  localparam int unsigned CTL_W = $bits(pirt_pkg::cmd_ctl_t);
  localparam int unsigned Q_W   = CTL_W + 2 * OFFSET_BITS;

  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_valid;
  pirt_pkg::cmd_ctl_t     f_ctl;
  logic [OFFSET_BITS-1:0] f_a;
  logic [OFFSET_BITS-1:0] f_b;
  logic [Q_W-1:0]         q_head;
  pirt_pkg::cmd_ctl_t     h_ctl;
  logic [OFFSET_BITS-1:0] h_a;
  logic [OFFSET_BITS-1:0] h_b;

  pirt_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .mode               (mode),
    .condition_inactive (condition_inactive),
    .line_start         (line_start),
    .after_line         (after_line),
    .seed_code          (seed_code),
    .bound_offset       (bound_offset),
    .cmd_full           (q_full),
    .cmd_push           (q_push),
    .cmd_ctl            (f_ctl),
    .cmd_a              (f_a),
    .cmd_b              (f_b)
  );

  pirt_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  ({f_ctl, f_a, f_b}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign h_ctl = pirt_pkg::cmd_ctl_t'(q_head[Q_W-1 -: CTL_W]);
  assign h_a   = q_head[2*OFFSET_BITS-1 -: OFFSET_BITS];
  assign h_b   = q_head[OFFSET_BITS-1:0];

  pirt_back #(
    .MAX_DEPTH   (MAX_DEPTH),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (q_valid),
    .cmd_ctl        (h_ctl),
    .cmd_a          (h_a),
    .cmd_b          (h_b),
    .cmd_pop        (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .item_kind      (item_kind),
    .region_valid   (region_valid),
    .region_begin   (region_begin),
    .region_end     (region_end),
    .level_code     (level_code),
    .depth_overflow (depth_overflow),
    .last           (last)
  );

`ifndef SYNTHESIS
  // A reported region is never empty
  a_region_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && region_valid |-> region_begin < region_end)
    else $error("region begin not below region end");

  // A directive region is a single, final result with no level code
  a_directive_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == pirt_pkg::KIND_REGION |->
      last && region_valid && level_code == '0)
    else $error("malformed directive region result");

  // An empty-stack finish is a single result with no region
  a_empty_finish: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == pirt_pkg::KIND_EMPTY |->
      last && !region_valid && level_code == '0)
    else $error("malformed empty finish result");
`endif

endmodule

`default_nettype wire
